FILE: hw/rtl/u128ca_pkg.sv
// Shared types and constants for the 128-bit checked ALU.
package u128ca_pkg;

    localparam int unsigned WORD_W  = 128;
    localparam int unsigned HALF_W  = 64;
    localparam int unsigned SUM_W   = WORD_W + 3;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned REM_W   = 4;
    localparam int unsigned SHAMT_W = 7;
    localparam logic [CNT_W-1:0]   FULL_CNT = CNT_W'(WORD_W);
    localparam logic [REM_W:0]     DIVISOR  = 5'd10;

    // Command codes
    typedef enum logic [3:0] {
        CMD_ADD    = 4'd0,
        CMD_ADDW   = 4'd1,
        CMD_SUB    = 4'd2,
        CMD_SUBW   = 4'd3,
        CMD_SHL    = 4'd4,
        CMD_MUL10  = 4'd5,
        CMD_DIV10  = 4'd6,
        CMD_GTE    = 4'd7,
        CMD_BITW   = 4'd8
    } t_cmd;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    // Controls from the sequencer to the datapath
    typedef struct packed {
        logic             load;
        logic             step;
        logic             fin;
        logic [3:0]       cmd;
        logic [CNT_W-1:0] cnt;
    } t_ctl;

endpackage

FILE: hw/rtl/u128ca_ctrl.sv
// Sequencer: accepts a request, counts iterations, strobes the result.
module u128ca_ctrl import u128ca_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [3:0]         i_command,
    input  logic [SHAMT_W-1:0] i_shift_amount,
    input  logic               i_acc_msb,
    output logic               busy,
    output logic               o_valid,
    output t_ctl               o_ctl
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [3:0]       r_cmd, n_cmd;
    logic             load, step, fin;

    // State, counter and command registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_cmd   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_cmd   <= n_cmd;
        end
    end

    // Next state and controls
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_cmd   = r_cmd;
        load    = 1'b0;
        step    = 1'b0;
        fin     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    load    = 1'b1;
                    n_cmd   = i_command;
                    n_state = ST_RUN;
                    case (i_command)
                        CMD_SHL:            n_cnt = CNT_W'(i_shift_amount);
                        CMD_DIV10, CMD_BITW: n_cnt = FULL_CNT;
                        default:            n_cnt = '0;
                    endcase
                end
            end
            ST_RUN: begin
                // bit width stops early once the leading one reaches the top
                if (r_cnt != '0 && !(r_cmd == CMD_BITW && i_acc_msb)) begin
                    step  = 1'b1;
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    fin     = 1'b1;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_DONE);

    assign o_ctl.load = load;
    assign o_ctl.step = step;
    assign o_ctl.fin  = fin;
    assign o_ctl.cmd  = load ? i_command : r_cmd;
    assign o_ctl.cnt  = r_cnt;

endmodule

FILE: hw/rtl/u128ca_dpath.sv
// Datapath: accumulator, operand register and the shared 131-bit adder.
module u128ca_dpath import u128ca_pkg::*; (
    input  logic              i_clk,
    input  t_ctl              i_ctl,
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_b,
    output logic              o_acc_msb,
    output logic [WORD_W-1:0] o_result,
    output logic [REM_W-1:0]  o_remainder,
    output logic              o_ok,
    output logic              o_is_ge
);

    logic [WORD_W-1:0] r_acc, n_acc;
    logic [WORD_W-1:0] r_b, n_b;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic              r_ok, n_ok;
    logic              r_ge, n_ge;

    logic [SUM_W-1:0]  add_x, add_y, sum;
    logic              add_cin;
    logic [REM_W:0]    rem_try;
    logic              q_bit;
    logic              carry, mul_ovf;

    // Shared adder operand selection
    always_comb begin
        add_x   = {3'b000, r_acc};
        add_y   = {3'b000, r_b};
        add_cin = 1'b0;
        case (i_ctl.cmd) inside
            CMD_SUB, CMD_SUBW, CMD_GTE: begin
                add_y   = {3'b000, ~r_b};
                add_cin = 1'b1;
            end
            CMD_MUL10: begin
                add_x = {r_acc, 3'b000};
                add_y = {2'b00, r_acc, 1'b0};
            end
            default: ;
        endcase
    end

    assign sum     = add_x + add_y + SUM_W'(add_cin);
    assign carry   = sum[WORD_W];
    // any of the top three bits of A set means 10*A cannot fit, and the 131-bit sum may wrap
    assign mul_ovf = (|r_acc[WORD_W-1:WORD_W-3]) | (|sum[SUM_W-1:WORD_W]);

    // Restoring divide by ten, one quotient bit per step
    assign rem_try = {r_rem, r_acc[WORD_W-1]};
    assign q_bit   = (rem_try >= DIVISOR);

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_b   <= n_b;
        r_rem <= n_rem;
        r_ok  <= n_ok;
        r_ge  <= n_ge;
    end

    // Register updates for load, iteration and final steps
    always_comb begin
        n_acc = r_acc;
        n_b   = r_b;
        n_rem = r_rem;
        n_ok  = r_ok;
        n_ge  = r_ge;
        if (i_ctl.load) begin
            n_acc = i_a;
            // shift keeps a copy of A to restore on overflow
            n_b   = (i_ctl.cmd == CMD_SHL) ? i_a : i_b;
            n_rem = '0;
            n_ok  = 1'b1;
            n_ge  = 1'b0;
        end else if (i_ctl.step) begin
            case (i_ctl.cmd)
                CMD_SHL: begin
                    if (r_acc[WORD_W-1]) begin
                        n_ok = 1'b0;
                    end
                    n_acc = {r_acc[WORD_W-2:0], 1'b0};
                end
                CMD_DIV10: begin
                    n_acc = {r_acc[WORD_W-2:0], q_bit};
                    n_rem = q_bit ? REM_W'(rem_try - DIVISOR) : rem_try[REM_W-1:0];
                end
                default: begin
                    n_acc = {r_acc[WORD_W-2:0], 1'b0};
                end
            endcase
        end else if (i_ctl.fin) begin
            case (i_ctl.cmd) inside
                CMD_ADD: begin
                    n_ok = ~carry;
                    if (!carry) begin
                        n_acc = sum[WORD_W-1:0];
                    end
                end
                CMD_ADDW, CMD_SUBW: begin
                    n_acc = sum[WORD_W-1:0];
                end
                CMD_SUB: begin
                    // carry out set means no borrow
                    n_ok = carry;
                    if (carry) begin
                        n_acc = sum[WORD_W-1:0];
                    end
                end
                CMD_MUL10: begin
                    n_ok = ~mul_ovf;
                    if (!mul_ovf) begin
                        n_acc = sum[WORD_W-1:0];
                    end
                end
                CMD_SHL: begin
                    if (!r_ok) begin
                        n_acc = r_b;
                    end
                end
                CMD_DIV10: ;
                CMD_GTE: begin
                    n_ge  = carry;
                    n_acc = '0;
                end
                CMD_BITW: begin
                    n_acc = WORD_W'(i_ctl.cnt);
                end
                default: begin
                    n_acc = '0;
                end
            endcase
        end
    end

    assign o_acc_msb   = r_acc[WORD_W-1];
    assign o_result    = r_acc;
    assign o_remainder = r_rem;
    assign o_ok        = r_ok;
    assign o_is_ge     = r_ge;

endmodule

FILE: hw/rtl/u128_checked_alu_unit.sv
// Top level of the 128-bit checked ALU: sequencer plus shared-adder datapath.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------------------------
//  request   | start in, busy out         | i_command, i_a_*, i_b_*, i_shift_amount
//  result    | o_valid out (one cycle)    | o_result_*, o_remainder, o_ok, o_is_ge
//
// A request is taken when start is high and busy is low. Each passes through load,
// iteration steps (shift: shift_amount of them; divide by ten: one quotient bit
// per cycle through the restoring step; bit width: until the leading one reaches
// the top; others: none), a finishing step and the strobe. busy stays high until
// the strobe ends. The receiver cannot stall; reset is synchronous, active low.
module u128_checked_alu_unit import u128ca_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         i_command,
    input  logic [HALF_W-1:0]  i_a_high,
    input  logic [HALF_W-1:0]  i_a_low,
    input  logic [HALF_W-1:0]  i_b_high,
    input  logic [HALF_W-1:0]  i_b_low,
    input  logic [SHAMT_W-1:0] i_shift_amount,
    output logic               o_valid,
    output logic [HALF_W-1:0]  o_result_high,
    output logic [HALF_W-1:0]  o_result_low,
    output logic [REM_W-1:0]   o_remainder,
    output logic               o_ok,
    output logic               o_is_ge
);

    t_ctl              ctl;
    logic              acc_msb;
    logic [WORD_W-1:0] result;

    u128ca_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_command      (i_command),
        .i_shift_amount (i_shift_amount),
        .i_acc_msb      (acc_msb),
        .busy           (busy),
        .o_valid        (o_valid),
        .o_ctl          (ctl)
    );

    u128ca_dpath u_dpath (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_a         ({i_a_high, i_a_low}),
        .i_b         ({i_b_high, i_b_low}),
        .o_acc_msb   (acc_msb),
        .o_result    (result),
        .o_remainder (o_remainder),
        .o_ok        (o_ok),
        .o_is_ge     (o_is_ge)
    );

    assign o_result_high = result[WORD_W-1:HALF_W];
    assign o_result_low  = result[HALF_W-1:0];

endmodule
